FILE: rtl/sdspi_pkg.sv
`default_nettype none

package sdspi_pkg;

   // input selector codes
   localparam logic [1:0] CMD_START_INIT = 2'd0;
   localparam logic [1:0] CMD_START_READ = 2'd1;
   localparam logic [1:0] CMD_RX_BYTE    = 2'd2;

   // configuration register indexes
   localparam logic [7:0] CSR_RESPONSE_WAIT = 8'd0;
   localparam logic [7:0] CSR_TOKEN_WAIT    = 8'd1;

   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 16;

   localparam logic [7:0]  RESPONSE_WAIT_RESET = 8'd200;
   localparam logic [15:0] TOKEN_WAIT_RESET    = 16'd30000;

   // card kinds
   localparam logic [1:0] CARD_NONE = 2'd0;
   localparam logic [1:0] CARD_V1   = 2'd1;
   localparam logic [1:0] CARD_V2   = 2'd2;
   localparam logic [1:0] CARD_HC   = 2'd3;

   // protocol bytes
   localparam logic [7:0] BYTE_IDLE     = 8'hFF;
   localparam logic [7:0] CODE_CMD0     = 8'h40;
   localparam logic [7:0] CODE_CMD8     = 8'h48;
   localparam logic [7:0] CODE_CMD55    = 8'h77;
   localparam logic [7:0] CODE_ACMD41   = 8'h69;
   localparam logic [7:0] CODE_CMD58    = 8'h7A;
   localparam logic [7:0] CODE_CMD17    = 8'h51;
   localparam logic [7:0] CRC_CMD0      = 8'h95;
   localparam logic [7:0] CRC_CMD8      = 8'h87;
   localparam logic [7:0] R1_IDLE       = 8'h01;
   localparam logic [7:0] R1_ILLEGAL    = 8'h05;
   localparam logic [7:0] R1_READY      = 8'h00;
   localparam logic [7:0] START_TOKEN   = 8'hFE;
   localparam logic [31:0] ARG_CMD8     = 32'h0000_01AA;
   localparam logic [31:0] ARG_ACMD41   = 32'h4000_0000;
   localparam logic [15:0] IDLE_CLOCK_BYTES = 16'd16;

   // result beat layout
   localparam int RSP_TX_VALID_BIT = 8;
   localparam int RSP_CS_BIT       = 9;
   localparam int RSP_DONE_BIT     = 10;
   localparam int RSP_STATUS_BIT   = 11;
   localparam int RSP_DATA_W       = 16;
   localparam int REQ_DATA_W       = 40;

   typedef enum logic [3:0] {
      PH_IDLE,
      PH_HOLD,
      PH_CLOCKS,
      PH_CMD0,
      PH_CMD8,
      PH_ECHO,
      PH_CMD55,
      PH_ACMD41,
      PH_CMD58,
      PH_OCR,
      PH_CMD17,
      PH_TOKEN
   } phase_type;

   function automatic logic [7:0] code_of(input phase_type p);
      logic [7:0] c;
      unique case (p)
         PH_CMD0:   c = CODE_CMD0;
         PH_CMD8:   c = CODE_CMD8;
         PH_CMD55:  c = CODE_CMD55;
         PH_ACMD41: c = CODE_ACMD41;
         PH_CMD58:  c = CODE_CMD58;
         default:   c = CODE_CMD17;
      endcase
      return c;
   endfunction

   function automatic logic [7:0] crc_of(input phase_type p);
      logic [7:0] c;
      if (p == PH_CMD0) c = CRC_CMD0;
      else if (p == PH_CMD8) c = CRC_CMD8;
      else c = BYTE_IDLE;
      return c;
   endfunction

   // byte of a command frame: idle, code, argument MSB first, crc
   function automatic logic [7:0] frame_byte(input phase_type p, input logic [2:0] idx,
                                             input logic [31:0] arg);
      logic [7:0] b;
      case (idx)
         3'd0:    b = BYTE_IDLE;
         3'd1:    b = code_of(p);
         3'd2:    b = arg[31:24];
         3'd3:    b = arg[23:16];
         3'd4:    b = arg[15:8];
         3'd5:    b = arg[7:0];
         default: b = crc_of(p);
      endcase
      return b;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/sd_spi_init_and_read_sequencer.sv
`default_nettype none

// SPI-mode SD card command sequencer, one byte exchange per beat.
// Request channel (req_): tuser selects start init, start block read or
// byte received; tdata carries the received byte and the sector number.
// Every accepted request beat yields exactly one response beat (rsp_)
// carrying the next byte to send, its valid flag, chip select, done,
// status and the detected card kind.
// CSR channel: csr_index 0 is the response poll limit, 1 the token poll
// limit; csr_ready is always high. Write only while no beat is pending.
// The response beat is registered and appears in the cycle after the request beat.
// Throughput: one beat per clock unless a stalled response holds it; the
// whole next-state and next-byte decode is one combinational pass into
// the response register. In use each beat stands for one SPI byte exchange.
// Reset (synchronous) returns to idle, card kind uninitialized and the
// limits to 200 and 30000, and empties the response register.
// A stalled response holds its beat; req_tready drops only while the
// response register is full and rsp_tready is low.
module sd_spi_init_and_read_sequencer
   import sdspi_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [1:0]             req_tuser,  // cmd[1:0]
   input  wire logic [REQ_DATA_W-1:0]  req_tdata,  // rx_byte[7:0], block_number[39:8]
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   // tx_byte[7:0], tx_valid[8], chip_select_active[9], done_res[10],
   // status[11], card_kind[13:12], zero[15:14]
   output logic [RSP_DATA_W-1:0]       rsp_tdata,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data
);

   logic [7:0]            resp_limit_ff;
   logic [15:0]           token_limit_ff;
   phase_type             phase_ff, phase_in;
   logic [2:0]            fbi_ff, fbi_in;
   logic [15:0]           retry_ff, retry_in;
   logic [1:0]            card_ff, card_in;
   logic [31:0]           arg_ff, arg_in;
   logic [7:0]            ocr_ff, ocr_in;
   logic [7:0]            poll_ff, poll_in;
   logic                  rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic       accept;
   logic [1:0] cmd;
   logic [7:0] rx;
   logic [31:0] blk;

   logic       fa_fin;
   logic [7:0] fa_resp;
   logic [7:0] fa_tx;
   logic [2:0] fa_fbi;
   logic [7:0] fa_poll;

   logic [7:0] tx_c;
   logic       valid_c, done_c, fail_c, cs_c;

   assign cmd = req_tuser;
   assign rx  = req_tdata[7:0];
   assign blk = req_tdata[39:8];

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign csr_ready  = 1'b1;

   // advance the current command frame and its response poll
   always_comb begin
      fa_fin  = 1'b0;
      fa_resp = BYTE_IDLE;
      fa_tx   = BYTE_IDLE;
      fa_fbi  = fbi_ff;
      fa_poll = poll_ff;
      if (fbi_ff < 3'd6) begin
         fa_fbi = fbi_ff + 3'd1;
         fa_tx  = frame_byte(phase_ff, fbi_ff + 3'd1, arg_ff);
      end else if (fbi_ff == 3'd6) begin
         fa_fbi  = 3'd7;
         fa_poll = 8'd0;
      end else if (rx != BYTE_IDLE) begin
         fa_fin  = 1'b1;
         fa_resp = rx;
      end else if (poll_ff >= resp_limit_ff) begin
         fa_fin = 1'b1;
      end else begin
         fa_poll = poll_ff + 8'd1;
      end
   end

   // next state and response beat for one request beat
   always_comb begin
      phase_in = phase_ff;
      fbi_in   = fbi_ff;
      retry_in = retry_ff;
      card_in  = card_ff;
      arg_in   = arg_ff;
      ocr_in   = ocr_ff;
      poll_in  = poll_ff;
      tx_c     = 8'd0;
      valid_c  = 1'b0;
      done_c   = 1'b0;
      fail_c   = 1'b0;

      if (cmd == CMD_START_INIT) begin
         phase_in = PH_CLOCKS;
         fbi_in   = 3'd0;
         poll_in  = 8'd0;
         retry_in = 16'd1;
         tx_c     = BYTE_IDLE;
         valid_c  = 1'b1;
      end else if (cmd == CMD_START_READ) begin
         arg_in   = (card_ff == CARD_HC) ? blk : {blk[22:0], 9'd0};
         retry_in = 16'd0;
         phase_in = PH_CMD17;
         fbi_in   = 3'd0;
         poll_in  = 8'd0;
         tx_c     = BYTE_IDLE;
         valid_c  = 1'b1;
      end else if (cmd == CMD_RX_BYTE && phase_ff != PH_IDLE && phase_ff != PH_HOLD) begin
         valid_c = 1'b1;
         unique case (phase_ff)
            PH_CLOCKS: begin
               tx_c = BYTE_IDLE;
               if (retry_ff < IDLE_CLOCK_BYTES) begin
                  retry_in = retry_ff + 16'd1;
               end else begin
                  phase_in = PH_CMD0;
                  arg_in   = 32'd0;
                  fbi_in   = 3'd0;
                  poll_in  = 8'd0;
               end
            end
            PH_CMD0, PH_CMD8, PH_CMD55, PH_ACMD41, PH_CMD58, PH_CMD17: begin
               fbi_in  = fa_fbi;
               poll_in = fa_poll;
               tx_c    = fa_tx;
               if (fa_fin) begin
                  tx_c = BYTE_IDLE;
                  unique case (phase_ff)
                     PH_CMD0: begin
                        if (fa_resp == R1_IDLE) begin
                           phase_in = PH_CMD8;
                           arg_in   = ARG_CMD8;
                           fbi_in   = 3'd0;
                           poll_in  = 8'd0;
                        end else begin
                           done_c = 1'b1;
                           fail_c = 1'b1;
                        end
                     end
                     PH_CMD8: begin
                        if (fa_resp == R1_IDLE) begin
                           card_in  = CARD_V2;
                           phase_in = PH_ECHO;
                           fbi_in   = 3'd1;
                        end else if (fa_resp == R1_ILLEGAL) begin
                           card_in = CARD_V1;
                           done_c  = 1'b1;
                        end else begin
                           done_c = 1'b1;
                           fail_c = 1'b1;
                        end
                     end
                     PH_CMD55: begin
                        phase_in = PH_ACMD41;
                        arg_in   = ARG_ACMD41;
                        fbi_in   = 3'd0;
                        poll_in  = 8'd0;
                     end
                     PH_ACMD41: begin
                        if (fa_resp == R1_READY) begin
                           phase_in = PH_CMD58;
                           arg_in   = 32'd0;
                           fbi_in   = 3'd0;
                           poll_in  = 8'd0;
                        end else if (retry_ff >= {8'd0, resp_limit_ff}) begin
                           done_c = 1'b1;
                           fail_c = 1'b1;
                        end else begin
                           retry_in = retry_ff + 16'd1;
                           phase_in = PH_CMD55;
                           arg_in   = 32'd0;
                           fbi_in   = 3'd0;
                           poll_in  = 8'd0;
                        end
                     end
                     PH_CMD58: begin
                        phase_in = PH_OCR;
                        fbi_in   = 3'd1;
                     end
                     default: begin
                        // read command
                        if (fa_resp == R1_READY) begin
                           phase_in = PH_TOKEN;
                           retry_in = 16'd0;
                        end else if (retry_ff >= token_limit_ff) begin
                           done_c = 1'b1;
                           fail_c = 1'b1;
                        end else begin
                           retry_in = retry_ff + 16'd1;
                           fbi_in   = 3'd0;
                           poll_in  = 8'd0;
                        end
                     end
                  endcase
               end
            end
            PH_ECHO: begin
               tx_c = BYTE_IDLE;
               if (fbi_ff < 3'd4) begin
                  fbi_in = fbi_ff + 3'd1;
               end else begin
                  retry_in = 16'd0;
                  phase_in = PH_CMD55;
                  arg_in   = 32'd0;
                  fbi_in   = 3'd0;
                  poll_in  = 8'd0;
               end
            end
            PH_OCR: begin
               tx_c = BYTE_IDLE;
               if (fbi_ff == 3'd1) ocr_in = rx;
               if (fbi_ff < 3'd4) begin
                  fbi_in = fbi_ff + 3'd1;
               end else begin
                  if (ocr_ff[6]) card_in = CARD_HC;
                  done_c = 1'b1;
               end
            end
            default: begin
               // start token poll
               tx_c = BYTE_IDLE;
               if (rx == START_TOKEN) begin
                  done_c = 1'b1;
               end else if (retry_ff >= token_limit_ff) begin
                  done_c = 1'b1;
                  fail_c = 1'b1;
               end else begin
                  retry_in = retry_ff + 16'd1;
               end
            end
         endcase

         // end of operation: no exchange, a read keeps chip select
         if (done_c) begin
            valid_c  = 1'b0;
            tx_c     = 8'd0;
            phase_in = (phase_ff == PH_CMD17 || phase_ff == PH_TOKEN) ? PH_HOLD : PH_IDLE;
         end
      end

      cs_c = (phase_in != PH_IDLE) && (phase_in != PH_CLOCKS);
      rsp_data_in = {2'b00, card_in, fail_c, done_c, cs_c, valid_c, tx_c};
   end

   // sequencer state, advanced on each accepted request beat
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         fbi_ff   <= 3'd0;
         retry_ff <= 16'd0;
         card_ff  <= CARD_NONE;
         arg_ff   <= 32'd0;
         ocr_ff   <= 8'd0;
         poll_ff  <= 8'd0;
      end else if (accept) begin
         phase_ff <= phase_in;
         fbi_ff   <= fbi_in;
         retry_ff <= retry_in;
         card_ff  <= card_in;
         arg_ff   <= arg_in;
         ocr_ff   <= ocr_in;
         poll_ff  <= poll_in;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         resp_limit_ff  <= RESPONSE_WAIT_RESET;
         token_limit_ff <= TOKEN_WAIT_RESET;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == CSR_RESPONSE_WAIT) resp_limit_ff <= csr_data[7:0];
         else if (csr_index == CSR_TOKEN_WAIT) token_limit_ff <= csr_data;
      end
   end

   // response register: load on accept, drop when taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) rsp_data_ff <= rsp_data_in;
   end

endmodule

`default_nettype wire

FILE: rtl/sdspi_checker.sv
`default_nettype none

module sdspi_checker
   import sdspi_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_tvalid,
   input wire logic                  req_tready,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic [RSP_DATA_W-1:0] rsp_tdata
);

   // a stalled response beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response beat changed while stalled");

   // every accepted request beat shows a response beat next cycle
   a_one_result: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> rsp_tvalid)
      else $error("request beat produced no response beat");

   // reset empties the response register
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // failure is only reported on the ending beat
   a_status_done: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[RSP_STATUS_BIT] |-> rsp_tdata[RSP_DONE_BIT])
      else $error("status set without done");

   // the ending beat requests no exchange
   a_done_no_tx: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[RSP_DONE_BIT]
      |-> !rsp_tdata[RSP_TX_VALID_BIT] && rsp_tdata[7:0] == 8'd0)
      else $error("exchange requested on ending beat");

endmodule

bind sd_spi_init_and_read_sequencer sdspi_checker u_sdspi_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

FILE: tb/sv/sd_exchange_checker.sv
`timescale 1ns / 100ps

// Watches the request, response and register channels of the SD sequencer,
// predicts one response beat per accepted request beat and compares.
module sd_exchange_checker
   import sdspi_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [1:0]             req_tuser,
   input  logic [REQ_DATA_W-1:0]  req_tdata,
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   output int                     mismatch_count,
   output int                     beats_pending
);

   localparam int KIND_LSB    = RSP_STATUS_BIT + 1;
   localparam int PAD_LSB     = KIND_LSB + 2;
   localparam int OCR_CCS_BIT = 6;

   typedef struct packed {
      logic [7:0] tx_byte;
      logic       tx_valid;
      logic       cs_active;
      logic       done;
      logic       status;
      logic [1:0] card_kind;
   } sd_result_type;

   sd_result_type pending_exchanges[$];
   int            err_total;

   // shadow of the sequencer state and limits
   phase_type   seq_phase;
   logic [3:0]  byte_idx;
   logic [15:0] retry_cnt;
   logic [1:0]  kind;
   logic [31:0] cmd_arg;
   logic [7:0]  ocr_first;
   logic [7:0]  poll_cnt;
   logic [7:0]  rsp_limit;
   logic [15:0] tok_limit;

   function automatic void clear_shadow();
      seq_phase = PH_IDLE;
      byte_idx  = '0;
      retry_cnt = '0;
      kind      = CARD_NONE;
      cmd_arg   = '0;
      ocr_first = '0;
      poll_cnt  = '0;
      rsp_limit = RESPONSE_WAIT_RESET;
      tok_limit = TOKEN_WAIT_RESET;
   endfunction

   // byte at a position of the current command frame
   function automatic logic [7:0] frame_out(input logic [3:0] idx);
      logic [7:0] b;
      case (idx)
         4'd0: b = BYTE_IDLE;
         4'd1: begin
            case (seq_phase)
               PH_CMD0:   b = CODE_CMD0;
               PH_CMD8:   b = CODE_CMD8;
               PH_CMD55:  b = CODE_CMD55;
               PH_ACMD41: b = CODE_ACMD41;
               PH_CMD58:  b = CODE_CMD58;
               default:   b = CODE_CMD17;
            endcase
         end
         4'd2: b = cmd_arg[31:24];
         4'd3: b = cmd_arg[23:16];
         4'd4: b = cmd_arg[15:8];
         4'd5: b = cmd_arg[7:0];
         default: begin
            if (seq_phase == PH_CMD0) b = CRC_CMD0;
            else if (seq_phase == PH_CMD8) b = CRC_CMD8;
            else b = BYTE_IDLE;
         end
      endcase
      return b;
   endfunction

   function automatic logic [7:0] open_frame(input phase_type p, input logic [31:0] arg);
      seq_phase = p;
      cmd_arg   = arg;
      byte_idx  = '0;
      poll_cnt  = '0;
      return BYTE_IDLE;
   endfunction

   // send the frame, then poll; returns 1 once the card answer is known
   function automatic bit frame_step(input logic [7:0] rx, output logic [7:0] answer,
                                     output logic [7:0] tx);
      answer = R1_READY;
      tx     = BYTE_IDLE;
      if (byte_idx < 4'd6) begin
         byte_idx = byte_idx + 4'd1;
         tx = frame_out(byte_idx);
         return 1'b0;
      end
      if (byte_idx == 4'd6) begin
         byte_idx = 4'd7;
         poll_cnt = '0;
         return 1'b0;
      end
      if (rx != BYTE_IDLE) begin
         answer = rx;
         return 1'b1;
      end
      if (poll_cnt >= rsp_limit) begin
         answer = BYTE_IDLE;
         return 1'b1;
      end
      poll_cnt = poll_cnt + 8'd1;
      return 1'b0;
   endfunction

   function automatic sd_result_type predict_exchange(input logic [1:0] sel,
                                                      input logic [7:0] rx,
                                                      input logic [31:0] sector);
      sd_result_type r;
      logic [7:0] tx;
      logic [7:0] answer;
      bit         valid;
      bit         done;
      bit         fail;
      tx    = '0;
      valid = 1'b0;
      done  = 1'b0;
      fail  = 1'b0;
      if (sel == CMD_START_INIT) begin
         seq_phase = PH_CLOCKS;
         byte_idx  = '0;
         poll_cnt  = '0;
         retry_cnt = 16'd1;
         tx        = BYTE_IDLE;
         valid     = 1'b1;
      end else if (sel == CMD_START_READ) begin
         retry_cnt = '0;
         // standard capacity cards take a byte address
         tx = open_frame(PH_CMD17, (kind == CARD_HC) ? sector : {sector[22:0], 9'd0});
         valid = 1'b1;
      end else if (sel == CMD_RX_BYTE && seq_phase != PH_IDLE && seq_phase != PH_HOLD) begin
         valid = 1'b1;
         case (seq_phase)
            PH_CLOCKS: begin
               if (retry_cnt < IDLE_CLOCK_BYTES) begin
                  retry_cnt = retry_cnt + 16'd1;
                  tx = BYTE_IDLE;
               end else tx = open_frame(PH_CMD0, '0);
            end
            PH_CMD0: begin
               if (frame_step(rx, answer, tx)) begin
                  if (answer == R1_IDLE) tx = open_frame(PH_CMD8, ARG_CMD8);
                  else begin
                     done = 1'b1;
                     fail = 1'b1;
                  end
               end
            end
            PH_CMD8: begin
               if (frame_step(rx, answer, tx)) begin
                  if (answer == R1_IDLE) begin
                     kind      = CARD_V2;
                     seq_phase = PH_ECHO;
                     byte_idx  = 4'd1;
                     tx        = BYTE_IDLE;
                  end else if (answer == R1_ILLEGAL) begin
                     kind = CARD_V1;
                     done = 1'b1;
                  end else begin
                     done = 1'b1;
                     fail = 1'b1;
                  end
               end
            end
            PH_ECHO: begin
               if (byte_idx < 4'd4) begin
                  byte_idx = byte_idx + 4'd1;
                  tx = BYTE_IDLE;
               end else begin
                  retry_cnt = '0;
                  tx = open_frame(PH_CMD55, '0);
               end
            end
            PH_CMD55: begin
               // the CMD55 answer itself does not matter
               if (frame_step(rx, answer, tx)) tx = open_frame(PH_ACMD41, ARG_ACMD41);
            end
            PH_ACMD41: begin
               if (frame_step(rx, answer, tx)) begin
                  if (answer == R1_READY) tx = open_frame(PH_CMD58, '0);
                  else if (retry_cnt >= {8'd0, rsp_limit}) begin
                     done = 1'b1;
                     fail = 1'b1;
                  end else begin
                     retry_cnt = retry_cnt + 16'd1;
                     tx = open_frame(PH_CMD55, '0);
                  end
               end
            end
            PH_CMD58: begin
               if (frame_step(rx, answer, tx)) begin
                  seq_phase = PH_OCR;
                  byte_idx  = 4'd1;
                  tx        = BYTE_IDLE;
               end
            end
            PH_OCR: begin
               if (byte_idx == 4'd1) ocr_first = rx;
               if (byte_idx < 4'd4) begin
                  byte_idx = byte_idx + 4'd1;
                  tx = BYTE_IDLE;
               end else begin
                  if (ocr_first[OCR_CCS_BIT]) kind = CARD_HC;
                  done = 1'b1;
               end
            end
            PH_CMD17: begin
               if (frame_step(rx, answer, tx)) begin
                  if (answer == R1_READY) begin
                     seq_phase = PH_TOKEN;
                     retry_cnt = '0;
                     tx        = BYTE_IDLE;
                  end else if (retry_cnt >= tok_limit) begin
                     done = 1'b1;
                     fail = 1'b1;
                  end else begin
                     retry_cnt = retry_cnt + 16'd1;
                     tx = open_frame(PH_CMD17, cmd_arg);
                  end
               end
            end
            default: begin
               if (rx == START_TOKEN) done = 1'b1;
               else if (retry_cnt >= tok_limit) begin
                  done = 1'b1;
                  fail = 1'b1;
               end else begin
                  retry_cnt = retry_cnt + 16'd1;
                  tx = BYTE_IDLE;
               end
            end
         endcase
         // reads keep chip select asserted afterwards
         if (done) begin
            valid = 1'b0;
            seq_phase = (seq_phase == PH_CMD17 || seq_phase == PH_TOKEN) ? PH_HOLD : PH_IDLE;
         end
      end
      r.tx_byte   = valid ? tx : 8'd0;
      r.tx_valid  = valid;
      r.cs_active = (seq_phase != PH_IDLE && seq_phase != PH_CLOCKS);
      r.done      = done;
      r.status    = fail;
      r.card_kind = kind;
      return r;
   endfunction

   function automatic int field_differs(input string name, input logic [7:0] want,
                                        input logic [7:0] seen);
      if (want !== seen) begin
         $error("%s mismatch: expected %0h, got %0h", name, want, seen);
         return 1;
      end
      return 0;
   endfunction

   always @(posedge clock) begin
      sd_result_type want;
      if (reset) begin
         clear_shadow();
         pending_exchanges.delete();
         err_total = 0;
      end else begin
         // compare the response beat with the oldest prediction
         if (rsp_tvalid && rsp_tready) begin
            if (pending_exchanges.size() == 0) begin
               $error("response beat %04h with no request outstanding", rsp_tdata);
               err_total++;
            end else begin
               want = pending_exchanges.pop_front();
               err_total += field_differs("tx_byte", want.tx_byte, rsp_tdata[7:0]);
               err_total += field_differs("tx_valid", {7'd0, want.tx_valid},
                                          {7'd0, rsp_tdata[RSP_TX_VALID_BIT]});
               err_total += field_differs("chip_select_active", {7'd0, want.cs_active},
                                          {7'd0, rsp_tdata[RSP_CS_BIT]});
               err_total += field_differs("done_res", {7'd0, want.done},
                                          {7'd0, rsp_tdata[RSP_DONE_BIT]});
               err_total += field_differs("status", {7'd0, want.status},
                                          {7'd0, rsp_tdata[RSP_STATUS_BIT]});
               err_total += field_differs("card_kind", {6'd0, want.card_kind},
                                          {6'd0, rsp_tdata[KIND_LSB +: 2]});
               err_total += field_differs("padding", 8'd0,
                                          8'(rsp_tdata[RSP_DATA_W-1:PAD_LSB]));
            end
         end
         // predict the answer to an accepted request beat
         if (req_tvalid && req_tready)
            pending_exchanges.push_back(predict_exchange(req_tuser, req_tdata[7:0],
                                                         req_tdata[39:8]));
         // register writes take effect after this edge
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_RESPONSE_WAIT) rsp_limit = csr_data[7:0];
            else if (csr_index == CSR_TOKEN_WAIT) tok_limit = csr_data;
         end
      end
      mismatch_count <= err_total;
      beats_pending  <= pending_exchanges.size();
   end

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;
   import sdspi_pkg::*;

   localparam logic [1:0]             CMD_UNUSED      = 2'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNMAPPED    = 8'hFF;
   localparam int                     WATCHDOG_CYCLES = 4000;
   localparam int                     ROUND_ITEMS     = 40;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [1:0]             req_tuser;  // cmd[1:0]
   logic [REQ_DATA_W-1:0]  req_tdata;  // rx_byte[7:0], block_number[39:8]
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   // tx_byte[7:0], tx_valid[8], chip_select_active[9], done_res[10],
   // status[11], card_kind[13:12], zero[15:14]
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;

   int fail_count;
   int beats_pending;
   int items_sent;
   int idle_cycles;
   int cfg_rsp_limit = int'(RESPONSE_WAIT_RESET);
   int cfg_tok_limit = int'(TOKEN_WAIT_RESET);
   bit steady;

   sd_spi_init_and_read_sequencer u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   sd_exchange_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tuser      (req_tuser),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .mismatch_count (fail_count),
      .beats_pending  (beats_pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // mostly short gaps, now and then a long one
   function automatic int idle_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 94) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // number of busy polls before an answer, up to the limit
   function automatic int poll_span(input int limit);
      int r;
      r = $urandom_range(0, 29);
      if (r < 18) return 0;
      if (r < 29) return $urandom_range(0, (limit < 3) ? limit : 3);
      return (limit <= 300) ? limit : $urandom_range(0, 5);
   endfunction

   // random byte, never idle and never one of the two given
   function automatic logic [7:0] byte_except(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] v;
      do v = 8'($urandom_range(0, 255));
      while (v == a || v == b || v == BYTE_IDLE);
      return v;
   endfunction

   // let the card stay silent now and then when a timeout is cheap
   function automatic logic [7:0] maybe_silent(input logic [7:0] answer);
      if (cfg_rsp_limit <= 20 && $urandom_range(0, 5) == 0) return BYTE_IDLE;
      return answer;
   endfunction

   function automatic logic [7:0] token_miss();
      logic [7:0] v;
      if ($urandom_range(0, 1) == 0) return BYTE_IDLE;
      do v = 8'($urandom_range(0, 255));
      while (v == START_TOKEN);
      return v;
   endfunction

   task automatic exchange(input logic [1:0] sel, input logic [7:0] rx,
                           input logic [31:0] sector);
      int gap;
      gap = steady ? 0 : idle_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= sel;
      req_tdata  <= {sector, rx};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (sel != CMD_UNUSED) items_sent++;
   endtask

   task automatic send_byte(input logic [7:0] rx);
      exchange(CMD_RX_BYTE, rx, $urandom);
   endtask

   task automatic send_filler(input int count);
      repeat (count) send_byte(8'($urandom_range(0, 255)));
   endtask

   // frame bytes, busy polls, then the answer; an idle answer means a timeout
   task automatic answer_frame(input logic [7:0] answer);
      int polls;
      polls = (answer == BYTE_IDLE) ? cfg_rsp_limit + 1 : poll_span(cfg_rsp_limit);
      send_filler(7);
      repeat (polls) send_byte(BYTE_IDLE);
      if (answer != BYTE_IDLE) send_byte(answer);
   endtask

   // drop valid and hold off until every response beat is back
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (beats_pending != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_limits(input int rsp_lim, input int tok_lim);
      logic [CSR_DATA_W-1:0] v;
      // upper bits of the response limit write are don't care
      v = 16'($urandom);
      v[7:0] = 8'(rsp_lim);
      write_register(CSR_RESPONSE_WAIT, v);
      write_register(CSR_TOKEN_WAIT, 16'(tok_lim));
      cfg_rsp_limit = rsp_lim;
      cfg_tok_limit = tok_lim;
   endtask

   // one initialization as a card would answer it, sometimes failing
   task automatic card_init();
      bit may_time_out;
      int busy_rounds;
      may_time_out = (cfg_rsp_limit <= 20);
      exchange(CMD_START_INIT, 8'($urandom_range(0, 255)), $urandom);
      send_filler(16);
      // CMD0: wrong answer or silence ends it
      case ($urandom_range(0, 19))
         0: begin
            answer_frame(byte_except(R1_IDLE, R1_IDLE));
            return;
         end
         1: begin
            if (may_time_out) begin
               answer_frame(BYTE_IDLE);
               return;
            end
         end
         default: ;
      endcase
      answer_frame(R1_IDLE);
      // CMD8: version 1 card, bad answer, or version 2
      case ($urandom_range(0, 9))
         0, 1: begin
            answer_frame(R1_ILLEGAL);
            return;
         end
         2: begin
            answer_frame(maybe_silent(byte_except(R1_IDLE, R1_ILLEGAL)));
            return;
         end
         default: answer_frame(R1_IDLE);
      endcase
      send_filler(4);
      // ACMD41 busy rounds, one more than allowed makes it give up
      busy_rounds = $urandom_range(0, 2);
      if (busy_rounds > cfg_rsp_limit) busy_rounds = cfg_rsp_limit;
      if ($urandom_range(0, 7) == 0 && cfg_rsp_limit <= 6) busy_rounds = cfg_rsp_limit + 1;
      repeat (busy_rounds) begin
         answer_frame(maybe_silent(byte_except(BYTE_IDLE, BYTE_IDLE)));
         answer_frame(maybe_silent(byte_except(R1_READY, R1_READY)));
      end
      if (busy_rounds > cfg_rsp_limit) return;
      answer_frame(maybe_silent(byte_except(BYTE_IDLE, BYTE_IDLE)));
      answer_frame(R1_READY);
      // CMD58, then the OCR bytes with a random capacity bit
      answer_frame(maybe_silent(byte_except(BYTE_IDLE, BYTE_IDLE)));
      send_filler(4);
   endtask

   // one block read: command retries, token polls, sometimes timing out
   task automatic card_read();
      logic [31:0] sector;
      int          retries;
      int          polls;
      case ($urandom_range(0, 7))
         0:       sector = '0;
         1:       sector = '1;
         default: sector = $urandom;
      endcase
      exchange(CMD_START_READ, 8'($urandom_range(0, 255)), sector);
      retries = $urandom_range(0, 2);
      if (retries > cfg_tok_limit) retries = cfg_tok_limit;
      if ($urandom_range(0, 7) == 0 && cfg_tok_limit <= 6) retries = cfg_tok_limit + 1;
      repeat (retries) answer_frame(maybe_silent(byte_except(R1_READY, R1_READY)));
      if (retries > cfg_tok_limit) return;
      answer_frame(R1_READY);
      polls = poll_span(cfg_tok_limit);
      if ($urandom_range(0, 9) == 0 && cfg_tok_limit <= 40) polls = cfg_tok_limit + 1;
      repeat (polls) send_byte(token_miss());
      if (polls <= cfg_tok_limit) send_byte(START_TOKEN);
   endtask

   task automatic line_noise();
      repeat ($urandom_range(1, 4))
         exchange(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)), $urandom);
   endtask

   task automatic directed_checks();
      // bytes while idle and the unused selector are ignored
      send_byte(8'h00);
      exchange(CMD_UNUSED, BYTE_IDLE, '1);
      // read before any initialization, widest sector number
      exchange(CMD_START_READ, 8'h00, 32'hFFFF_FFFF);
      send_filler(7);
      send_byte(R1_READY);
      send_byte(START_TOKEN);
      // byte after a finished read, chip select still held
      send_byte(8'h00);
      // initialization with the unused selector in between, cut short by a read
      exchange(CMD_START_INIT, 8'hFF, 32'h0000_0000);
      send_filler(1);
      exchange(CMD_UNUSED, 8'h00, 32'h0000_0000);
      send_filler(2);
      exchange(CMD_START_READ, 8'h5A, 32'h0000_0001);
      send_filler(2);
   endtask

   // response side: random stalls with stretches of steady acceptance
   initial begin
      int hold_off;
      int open_for;
      rsp_tready <= 1'b0;
      forever begin
         hold_off = idle_gap();
         open_for = $urandom_range(1, 6);
         if ($urandom_range(0, 19) == 0) begin
            hold_off = 0;
            open_for = $urandom_range(50, 150);
         end
         if (hold_off > 0) begin
            rsp_tready <= 1'b0;
            repeat (hold_off) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         repeat (open_for) @(posedge clock);
      end
   end

   // end the run if no channel moves a beat for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_CYCLES) begin
         $display("simulation failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int round;
      int goal;
      int pick;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tuser  <= CMD_RX_BYTE;
      req_tdata  <= '0;
      csr_valid  <= 1'b0;
      csr_index  <= CSR_RESPONSE_WAIT;
      csr_data   <= '0;
      items_sent  = 0;
      steady      = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      directed_checks();

      // first round at reset limits, then extremes, then small random limits
      for (round = 0; round < 8; round++) begin
         if (round > 0) begin
            settle();
            case (round)
               1: set_limits(0, 0);
               2: begin
                  set_limits(1, 1);
                  write_register(CSR_UNMAPPED, 16'($urandom));
               end
               3: set_limits(255, 65535);
               default: set_limits($urandom_range(0, 12), $urandom_range(0, 12));
            endcase
         end
         goal = items_sent + ROUND_ITEMS;
         while (items_sent < goal) begin
            steady = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 9) == 0) settle();
            pick = $urandom_range(0, 9);
            if (pick < 4) card_init();
            else if (pick < 8) card_read();
            else line_noise();
         end
      end

      settle();
      repeat (7) @(posedge clock);
      if (fail_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
